// ===== src/oaht_pkg.sv =====
`default_nettype none
package oaht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = 10;
    localparam int IDX_W       = 11;
    localparam int KEY_BYTES   = 10;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int SUM_W       = 32;
    localparam int WGT_W       = 16 * KEY_BYTES;

    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd_e;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_FULL      = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status_e;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_GONE  = 2'd2;

    localparam logic [1:0] REG_W_FIRST  = 2'd0;
    localparam logic [1:0] REG_W_MIDDLE = 2'd1;
    localparam logic [1:0] REG_W_LAST   = 2'd2;
    localparam logic [1:0] REG_T_SIZE   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_low;
        logic [15:0] key_high;
        logic [3:0]  key_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] slot_index;
    } t_out_item;

    typedef struct packed {
        logic [WGT_W-1:0] weights;
        logic [IDX_W-1:0] table_size;
    } t_hash_cfg;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
        logic [IDX_W-1:0]  n;
    } t_task;

endpackage
`default_nettype wire

// ===== src/oaht_front.sv =====
`default_nettype none
module oaht_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  oaht_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    input  oaht_pkg::t_hash_cfg i_cfg,
    output logic                o_push,
    output oaht_pkg::t_task     o_task,
    input  wire                 i_full
);
    import oaht_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_n, n_n;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [4:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0] r_rem, n_rem;

    logic [3:0]       len_sat;
    logic [KEY_W-1:0] raw_key, masked_key;
    logic [IDX_W-1:0] n_eff;
    logic [7:0]       byte_sel;
    logic [15:0]      w_sel;
    logic [23:0]      prod;
    logic [IDX_W:0]   trial;
    logic             trial_ge;

    always_comb begin
        len_sat = (i_in_data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                        : i_in_data.key_length;
        raw_key = {i_in_data.key_high, i_in_data.key_low};
        for (int b = 0; b < KEY_BYTES; b++) begin
            masked_key[8*b +: 8] = (4'(b) < len_sat) ? raw_key[8*b +: 8] : 8'd0;
        end
        if (i_cfg.table_size == '0) begin
            n_eff = IDX_W'(1);
        end else if (i_cfg.table_size > IDX_W'(TABLE_DEPTH)) begin
            n_eff = IDX_W'(TABLE_DEPTH);
        end else begin
            n_eff = i_cfg.table_size;
        end
    end

    assign byte_sel = r_key[{r_cnt[3:0], 3'b000} +: 8];
    assign w_sel    = i_cfg.weights[{r_cnt[3:0], 4'b0000} +: 16];
    assign prod     = 24'(byte_sel) * 24'(w_sel);
    assign trial    = {r_rem, r_sum[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, r_n};

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_n     = r_n;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_key   = masked_key;
                    n_n     = n_eff;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                n_sum = r_sum + SUM_W'(prod);
                if (r_cnt == 5'(KEY_BYTES - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = F_MOD;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            F_MOD: begin
                n_rem = trial_ge ? IDX_W'(trial - {1'b0, r_n}) : trial[IDX_W-1:0];
                n_sum = {r_sum[SUM_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(SUM_W - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_n   <= n_n;
        r_sum <= n_sum;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
    end

    assign o_in_stall  = (r_state != F_IDLE);
    assign o_task.cmd  = r_cmd;
    assign o_task.key  = r_key;
    assign o_task.home = r_rem[SLOT_W-1:0];
    assign o_task.n    = r_n;

endmodule
`default_nettype wire

// ===== src/oaht_queue.sv =====
`default_nettype none
module oaht_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  oaht_pkg::t_task i_task,
    output logic            o_full,
    input  wire             i_pop,
    output oaht_pkg::t_task o_head,
    output logic            o_empty
);
    import oaht_pkg::*;

    t_task      r_slots [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_slots[r_wr_ptr] <= i_task;
    end

    assign o_head  = r_slots[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule
`default_nettype wire

// ===== src/oaht_back.sv =====
`default_nettype none
module oaht_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  oaht_pkg::t_task     i_head,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output oaht_pkg::t_out_item o_out_data,
    input  wire                 i_out_stall
);
    import oaht_pkg::*;

    localparam int ENT_W = KEY_W + 2;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_CHECK = 4'b1000
    } t_bstate;

    logic [ENT_W-1:0]  r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]  r_rdata;

    t_bstate           r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_n, n_n;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_free_ok, n_free_ok;
    logic [SLOT_W-1:0] r_free_slot, n_free_slot;
    logic              r_report, n_report;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              out_take;
    logic [1:0]        st;
    logic              found, is_last, stop_absent, free_here, cand_ok;
    logic [SLOT_W-1:0] cand, slot_next;

    assign out_take    = r_out_valid & ~i_out_stall;
    assign st          = r_rdata[ENT_W-1 -: 2];
    assign found       = (st == SLOT_USED) && (r_rdata[KEY_W-1:0] == r_key);
    assign is_last     = (r_k + IDX_W'(1)) == r_n;
    assign stop_absent = (st == SLOT_EMPTY) || is_last;
    assign free_here   = (st != SLOT_USED);
    assign cand_ok     = r_free_ok | free_here;
    assign cand        = r_free_ok ? r_free_slot : r_slot;
    assign slot_next   = (({1'b0, r_slot} + IDX_W'(1)) == r_n) ? '0
                                                              : r_slot + SLOT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_n         = r_n;
        n_slot      = r_slot;
        n_k         = r_k;
        n_free_ok   = r_free_ok;
        n_free_slot = r_free_slot;
        n_report    = r_report;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_slot;
        wdata       = {SLOT_EMPTY, r_key};
        o_pop       = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                we = 1'b1;
                if (r_slot == SLOT_W'(TABLE_DEPTH - 1)) begin
                    if (r_report) begin
                        n_out_valid      = 1'b1;
                        n_out.status     = ST_CLEARED;
                        n_out.slot_index = r_n;
                    end
                    n_state = B_IDLE;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            B_IDLE: begin
                if (!i_empty && (!r_out_valid || out_take)) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_head.cmd;
                    n_key     = i_head.key;
                    n_n       = i_head.n;
                    n_k       = '0;
                    n_free_ok = 1'b0;
                    if (i_head.cmd == CMD_CLEAR) begin
                        n_slot   = '0;
                        n_report = 1'b1;
                        n_state  = B_CLEAR;
                    end else begin
                        n_slot  = i_head.home;
                        n_state = B_READ;
                    end
                end
            end
            B_READ: begin
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (found || stop_absent) begin
                    n_out_valid      = 1'b1;
                    n_out.slot_index = r_n;
                    n_out.status     = ST_NOT_FOUND;
                    n_state          = B_IDLE;
                end
                if (found) begin
                    n_out.slot_index = {1'b0, r_slot};
                    priority case (r_cmd)
                        CMD_SEARCH: n_out.status = ST_FOUND;
                        CMD_REMOVE: begin
                            we           = 1'b1;
                            wdata        = {SLOT_GONE, r_rdata[KEY_W-1:0]};
                            n_out.status = ST_REMOVED;
                        end
                        default: n_out.status = ST_PRESENT;
                    endcase
                end else if (stop_absent) begin
                    if (r_cmd == CMD_INSERT) begin
                        if (cand_ok) begin
                            we               = 1'b1;
                            waddr            = cand;
                            wdata            = {SLOT_USED, r_key};
                            n_out.status     = ST_INSERTED;
                            n_out.slot_index = {1'b0, cand};
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end
                end else begin
                    if (!r_free_ok && free_here) begin
                        n_free_ok   = 1'b1;
                        n_free_slot = r_slot;
                    end
                    n_k     = r_k + IDX_W'(1);
                    n_slot  = slot_next;
                    n_state = B_READ;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_slot      <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_n         <= n_n;
        r_k         <= n_k;
        r_free_ok   <= n_free_ok;
        r_free_slot <= n_free_slot;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== src/open_addressing_hash_table_core.sv =====
`default_nettype none
// Channel   Direction  Handshake                   Payload
// command   in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_stall   o_out_data (t_out_item)
// config    in         APB psel/penable/pwrite     paddr, pwdata, prdata
//
// Front end: a transaction hashes one weighted byte a cycle, then runs a
// one-bit-a-cycle restoring modulo, before it enters the queue.
// Back end: 1 to n probes on the slot memory (one write port, one read port),
// each one memory read then one compare; a clear sweeps all TABLE_DEPTH slots.
// Reset: a pass over all 1024 slots empties the slot memory; commands queue
// meanwhile. The front takes the next command while the back probes; the
// result register holds its transaction until the sink releases i_out_stall.
module open_addressing_hash_table_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  oaht_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output oaht_pkg::t_out_item o_out_data,
    input  wire                 i_out_stall,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [4:0]          paddr,
    input  wire  [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import oaht_pkg::*;

    // Configuration registers, 8-byte stride
    logic [63:0]      r_w_first, r_w_middle;
    logic [31:0]      r_w_last;
    logic [IDX_W-1:0] r_t_size;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    t_hash_cfg hash_cfg;
    t_task     push_task, head_task;
    logic      push, full, pop, empty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:3];

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_first  <= 64'd281479271743489;
            r_w_middle <= 64'd281479271743489;
            r_w_last   <= 32'd65537;
            r_t_size   <= IDX_W'(1024);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_W_FIRST:  r_w_first  <= pwdata;
                REG_W_MIDDLE: r_w_middle <= pwdata;
                REG_W_LAST:   r_w_last   <= pwdata[31:0];
                REG_T_SIZE:   r_t_size   <= pwdata[IDX_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (cfg_idx)
            REG_W_FIRST:  prdata = r_w_first;
            REG_W_MIDDLE: prdata = r_w_middle;
            REG_W_LAST:   prdata = {32'd0, r_w_last};
            REG_T_SIZE:   prdata = {53'd0, r_t_size};
        endcase
    end

    assign hash_cfg.weights    = {r_w_last, r_w_middle, r_w_first};
    assign hash_cfg.table_size = r_t_size;

    // Front: mask the key, hash it and reduce it to the home slot
    oaht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (hash_cfg),
        .o_push     (push),
        .o_task     (push_task),
        .i_full     (full)
    );

    // Queue: decouple hashing from probing
    oaht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_task),
        .o_empty (empty)
    );

    // Back: probe the slot memory and return one result per command
    oaht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_task),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
